### rtl/core/bphs_pkg.sv
`default_nettype none
package bphs_pkg;

	localparam int HDR_CAP = 31;
	localparam int PRM_CAP = 7;
	localparam int HPW = $clog2(HDR_CAP + 1);
	localparam int PPW = $clog2(PRM_CAP + 1);

	typedef logic [7:0] byte_t;

	typedef enum logic [2:0] {
		CMD_BYTE    = 3'd0,
		CMD_TICK    = 3'd1,
		CMD_RESTART = 3'd2,
		CMD_RUN     = 3'd3,
		CMD_UPGRADE = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_FLUSH    = 3'd0,
		ST_PROBE    = 3'd1,
		ST_HEADER   = 3'd2,
		ST_CONTENT  = 3'd3,
		ST_PROMPT   = 3'd4,
		ST_READY    = 3'd5,
		ST_TRANSFER = 3'd6
	} stage_t;

	localparam logic REG_ENABLED = 1'b0;
	localparam logic REG_QUIET   = 1'b1;

	localparam logic [15:0] QUIET_TICKS_RESET = 16'd100;
	localparam logic [15:0] QUIET_MAX         = 16'hFFFF;

	localparam byte_t CHAR_NL      = 8'd10;
	localparam byte_t CHAR_NUL     = 8'd0;
	localparam byte_t CHAR_READY   = 8'd67;
	localparam byte_t CHAR_RUN     = 8'd50;
	localparam byte_t CHAR_UPGRADE = 8'd49;

	localparam logic [HDR_CAP-1:0][7:0] HDR_TEXT = {
		120'd0,
		8'd114, 8'd101, 8'd100, 8'd97, 8'd111, 8'd108, 8'd116, 8'd111,
		8'd111, 8'd66, 8'd32, 8'd111, 8'd107, 8'd99, 8'd101, 8'd71
	};

	localparam logic [PRM_CAP-1:0][7:0] PRM_TEXT = {
		24'd0, 8'd62, 8'd32, 8'd76, 8'd66
	};

	function automatic int clamp_len(input int len, input int cap);
		if (len < 1) return 1;
		if (len > cap) return cap;
		return len;
	endfunction

endpackage
`default_nettype wire

### rtl/core/bphs_match.sv
`default_nettype none
module bphs_match
	import bphs_pkg::*;
#(
	parameter int CAP = 7,
	parameter int LEN = 4,
	parameter logic [CAP-1:0][7:0] PAT = '0
) (
	input  wire logic [$clog2(CAP+1)-1:0] prog,
	input  wire byte_t                    b,
	output logic      [$clog2(CAP+1)-1:0] next
);

	localparam int PW = $clog2(CAP + 1);
	localparam int L  = clamp_len(LEN, CAP);

	function automatic logic [CAP-1:0][CAP:0] build_border(input logic [CAP-1:0][7:0] pat);
		logic [CAP-1:0][CAP:0] t;
		logic                  ok;
		t = '0;
		for (int p = 0; p < CAP; p++) begin
			for (int k = 1; k <= p + 1; k++) begin
				ok = 1'b1;
				for (int j = 0; j + 1 < k; j++) begin
					if (pat[j] != pat[p-(k-1)+j]) ok = 1'b0;
				end
				t[p][k] = ok;
			end
		end
		return t;
	endfunction

	localparam logic [CAP-1:0][CAP:0] BORDER = build_border(PAT);

	logic [PW-1:0] pc;

	assign pc = (prog >= PW'(L)) ? PW'(L - 1) : prog;

	always_comb begin
		next = '0;
		for (int k = 1; k <= L; k++) begin
			if (PAT[k-1] == b && BORDER[pc][k]) next = PW'(k);
		end
	end

endmodule
`default_nettype wire

### rtl/core/bootloader_prompt_handshake_unit.sv
// The result word of an accepted input word is registered and shown in the next cycle.
// Throughput: one word per cycle; the single result register frees in the
// same cycle its word is taken, so input stalls only while output stalls.
// Reset (arst_n low): stage flush, matchers and timer cleared, enabled = 1,
// quiet_ticks = 100, no result pending.
`default_nettype none
module bootloader_prompt_handshake_unit
	import bphs_pkg::*;
#(
	parameter int HEADER_LENGTH = 16,
	parameter int PROMPT_LENGTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [7:0]  data_byte,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             tx_valid,
	output logic [7:0]       tx_byte,
	output logic             command_ok,
	output logic             prompt_seen,
	output logic             transfer_start,
	output logic [2:0]       stage_now
);

	localparam int HL = clamp_len(HEADER_LENGTH, HDR_CAP);
	localparam int PL = clamp_len(PROMPT_LENGTH, PRM_CAP);

	logic            enabled_q;
	logic [15:0]     quiet_ticks_q;
	stage_t          stage_q, stage_d;
	logic [HPW-1:0]  hdr_prog_q, hdr_prog_d, hdr_step;
	logic [PPW-1:0]  prm_prog_q, prm_prog_d, prm_step;
	logic [15:0]     quiet_cnt_q, quiet_cnt_d, quiet_inc;
	logic            quiet_armed_q, quiet_armed_d;
	logic            xfer_armed_q, xfer_armed_d;
	logic            out_valid_q;
	logic            accept;
	cmd_t            cmd;

	logic            tx_valid_d, command_ok_d, prompt_seen_d, transfer_start_d;
	byte_t           tx_byte_d;
	logic            probe_fire, select_ok, hdr_full, prm_full, ready_hit, byte_live;

	assign cmd       = cmd_t'(command);
	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	bphs_match #(.CAP(HDR_CAP), .LEN(HEADER_LENGTH), .PAT(HDR_TEXT)) u_hdr (
		.prog (hdr_prog_q),
		.b    (data_byte),
		.next (hdr_step)
	);

	bphs_match #(.CAP(PRM_CAP), .LEN(PROMPT_LENGTH), .PAT(PRM_TEXT)) u_prm (
		.prog (prm_prog_q),
		.b    (data_byte),
		.next (prm_step)
	);

	assign quiet_inc  = (quiet_cnt_q < QUIET_MAX) ? quiet_cnt_q + 16'd1 : quiet_cnt_q;
	assign probe_fire = quiet_armed_q && quiet_inc >= quiet_ticks_q;
	assign select_ok  = stage_q == ST_PROMPT && enabled_q;
	assign hdr_full   = hdr_step == HPW'(HL);
	assign prm_full   = prm_step == PPW'(PL);
	assign byte_live  = enabled_q && stage_q != ST_FLUSH;
	assign ready_hit  = stage_q == ST_READY && data_byte == CHAR_READY && xfer_armed_q;

	always_comb begin
		stage_d       = stage_q;
		hdr_prog_d    = hdr_prog_q;
		prm_prog_d    = prm_prog_q;
		quiet_cnt_d   = quiet_cnt_q;
		quiet_armed_d = quiet_armed_q;
		xfer_armed_d  = xfer_armed_q;
		case (cmd)
			CMD_BYTE: begin
				if (enabled_q && stage_q == ST_FLUSH) begin
					quiet_armed_d = 1'b1;
					quiet_cnt_d   = '0;
				end else if (byte_live) begin
					if (ready_hit) begin
						stage_d      = ST_TRANSFER;
						xfer_armed_d = 1'b0;
					end
					if (data_byte == CHAR_NUL) begin
						hdr_prog_d = '0;
						prm_prog_d = '0;
					end else if (hdr_full) begin
						stage_d    = ST_HEADER;
						hdr_prog_d = '0;
						prm_prog_d = '0;
					end else begin
						hdr_prog_d = hdr_step;
						if (stage_d == ST_HEADER && data_byte == CHAR_NL) stage_d = ST_CONTENT;
						if (prm_full) begin
							prm_prog_d = '0;
							if (stage_d inside {ST_HEADER, ST_CONTENT}) stage_d = ST_PROMPT;
						end else begin
							prm_prog_d = prm_step;
						end
					end
				end
			end
			CMD_TICK: begin
				if (quiet_armed_q) begin
					quiet_cnt_d = quiet_inc;
					if (probe_fire) begin
						quiet_armed_d = 1'b0;
						if (enabled_q) stage_d = ST_PROBE;
					end
				end
			end
			CMD_RESTART: begin
				stage_d       = ST_FLUSH;
				hdr_prog_d    = '0;
				prm_prog_d    = '0;
				xfer_armed_d  = 1'b0;
				quiet_armed_d = 1'b1;
				quiet_cnt_d   = '0;
			end
			CMD_RUN: begin
				if (select_ok) stage_d = ST_FLUSH;
			end
			CMD_UPGRADE: begin
				if (select_ok) begin
					stage_d      = ST_READY;
					xfer_armed_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		tx_valid_d       = 1'b0;
		tx_byte_d        = CHAR_NUL;
		command_ok_d     = 1'b0;
		prompt_seen_d    = 1'b0;
		transfer_start_d = 1'b0;
		case (cmd)
			CMD_BYTE: begin
				if (byte_live) begin
					transfer_start_d = ready_hit;
					prompt_seen_d    = data_byte != CHAR_NUL && !hdr_full && prm_full
						&& (stage_q == ST_HEADER || stage_q == ST_CONTENT);
				end
			end
			CMD_TICK: begin
				if (probe_fire && enabled_q) begin
					tx_valid_d = 1'b1;
					tx_byte_d  = CHAR_NL;
				end
			end
			CMD_RUN: begin
				if (select_ok) begin
					tx_valid_d   = 1'b1;
					command_ok_d = 1'b1;
					tx_byte_d    = CHAR_RUN;
				end
			end
			CMD_UPGRADE: begin
				if (select_ok) begin
					tx_valid_d   = 1'b1;
					command_ok_d = 1'b1;
					tx_byte_d    = CHAR_UPGRADE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q     <= 1'b1;
			quiet_ticks_q <= QUIET_TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLED: enabled_q     <= cfg_data[0];
				REG_QUIET:   quiet_ticks_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q       <= ST_FLUSH;
			hdr_prog_q    <= '0;
			prm_prog_q    <= '0;
			quiet_cnt_q   <= '0;
			quiet_armed_q <= 1'b0;
			xfer_armed_q  <= 1'b0;
		end else if (accept) begin
			stage_q       <= stage_d;
			hdr_prog_q    <= hdr_prog_d;
			prm_prog_q    <= prm_prog_d;
			quiet_cnt_q   <= quiet_cnt_d;
			quiet_armed_q <= quiet_armed_d;
			xfer_armed_q  <= xfer_armed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_valid       <= tx_valid_d;
			tx_byte        <= tx_byte_d;
			command_ok     <= command_ok_d;
			prompt_seen    <= prompt_seen_d;
			transfer_start <= transfer_start_d;
			stage_now      <= stage_d;
		end
	end

endmodule
`default_nettype wire
